// File: sv/cc_pkg.sv
// cc_pkg: shared constants, mode codes and command/status structs
// for the circular convolution block.
// No dependencies; imported by every module of the block.
package cc_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_LEN     = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed field widths
  localparam int MODE_W      = 2;
  localparam int PERIOD_W    = 7;
  localparam int INDEX_W     = 6;
  localparam int VALUE_W     = 38;
  localparam int OUT_TDATA_W = 48;
  localparam int ADDR_W      = 5;   // address field width for up to 32 entries

  localparam logic [PERIOD_W-1:0] MAX_PERIOD = 7'd64;

  // Input item kinds, carried on in_tuser
  localparam logic [MODE_W-1:0] MODE_LOAD_X  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_Y  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  // Sideband that travels with one product term down the pipeline
  typedef struct packed {
    logic               first;    // first term of output k
    logic               fin;      // final term of output k
    logic               use_term; // term lies inside both vectors
    logic               last;     // final output of the run
    logic               dropped;  // drop flag for this run
    logic [INDEX_W-1:0] k;
  } tag_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              valid;     // issue one product term
    tag_t              tag;
    logic [ADDR_W-1:0] xa;
    logic [ADDR_W-1:0] ya;
    logic              wr_x;      // store sample into x
    logic              wr_y;      // store sample into y
    logic [ADDR_W-1:0] wa;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic run;                    // pipeline advances this cycle
    logic busy;                   // terms still in flight
  } stat_t;

endpackage

// File: sv/cc_ctrl.sv
// cc_ctrl: controller for the circular convolution block. Holds the period
// register, vector fill counts and drop flag, and sequences the k/i loops.
// Depends on cc_pkg.
module cc_ctrl import cc_pkg::*; #(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [MODE_W-1:0]   in_tuser,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  input  stat_t               stat,
  output cmd_t                cmd
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [CW-1:0]       xc_r, xc_nxt;
  logic [CW-1:0]       yc_r, yc_nxt;
  logic                drop_r, drop_nxt;
  logic [PERIOD_W-1:0] n_r, n_nxt;
  logic [CW-1:0]       imax_r, imax_nxt;
  logic [CW-1:0]       ycrun_r, ycrun_nxt;
  logic                droprun_r, droprun_nxt;
  logic [INDEX_W-1:0]  k_r, k_nxt;
  logic [AW-1:0]       i_r, i_nxt;
  logic [INDEX_W-1:0]  j_r, j_nxt;

  logic                accept;
  logic [PERIOD_W-1:0] n_sel;
  logic [PERIOD_W-1:0] xc_ext;
  logic                fin, last_k, use_term;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign xc_ext    = PERIOD_W'(xc_r);

  // Period for a compute transaction
  always_comb begin
    if (period_r == '0) begin
      if (xc_r != '0 && yc_r != '0) begin
        n_sel = xc_ext + PERIOD_W'(yc_r) - PERIOD_W'(1);
      end else begin
        n_sel = '0;
      end
    end else if (period_r > MAX_PERIOD) begin
      n_sel = MAX_PERIOD;
    end else begin
      n_sel = period_r;
    end
  end

  // Loop flags for the current term
  assign fin      = (imax_r == '0) || ((CW'(i_r) + CW'(1)) == imax_r);
  assign last_k   = (PERIOD_W'(k_r) + PERIOD_W'(1)) == n_r;
  assign use_term = (imax_r != '0) && (PERIOD_W'(j_r) < PERIOD_W'(ycrun_r));

  // Commands to the datapath
  always_comb begin
    cmd              = '0;
    cmd.valid        = (state_r == ST_RUN);
    cmd.tag.first    = (i_r == '0);
    cmd.tag.fin      = fin;
    cmd.tag.use_term = use_term;
    cmd.tag.last     = fin && last_k;
    cmd.tag.dropped  = droprun_r;
    cmd.tag.k        = k_r;
    cmd.xa           = ADDR_W'(i_r);
    cmd.ya           = ADDR_W'(j_r);
    cmd.wr_x         = accept && (in_tuser == MODE_LOAD_X) && (xc_r != CW'(MAX_LEN));
    cmd.wr_y         = accept && (in_tuser == MODE_LOAD_Y) && (yc_r != CW'(MAX_LEN));
    cmd.wa           = (in_tuser == MODE_LOAD_X) ? ADDR_W'(xc_r) : ADDR_W'(yc_r);
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    xc_nxt      = xc_r;
    yc_nxt      = yc_r;
    drop_nxt    = drop_r;
    n_nxt       = n_r;
    imax_nxt    = imax_r;
    ycrun_nxt   = ycrun_r;
    droprun_nxt = droprun_r;
    k_nxt       = k_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_tuser)
            MODE_LOAD_X: begin
              if (cmd.wr_x) xc_nxt = xc_r + CW'(1);
              else          drop_nxt = 1'b1;
            end
            MODE_LOAD_Y: begin
              if (cmd.wr_y) yc_nxt = yc_r + CW'(1);
              else          drop_nxt = 1'b1;
            end
            MODE_COMPUTE: begin
              n_nxt       = n_sel;
              imax_nxt    = (xc_ext < n_sel) ? xc_r : CW'(n_sel);
              ycrun_nxt   = yc_r;
              droprun_nxt = drop_r;
              k_nxt       = '0;
              i_nxt       = '0;
              j_nxt       = '0;
              xc_nxt      = '0;
              yc_nxt      = '0;
              drop_nxt    = 1'b0;
              if (n_sel != '0) state_nxt = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (stat.run) begin
          if (fin) begin
            i_nxt = '0;
            k_nxt = k_r + INDEX_W'(1);
            j_nxt = k_r + INDEX_W'(1);
            if (last_k) state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + AW'(1);
            j_nxt = (j_r == '0) ? INDEX_W'(n_r - PERIOD_W'(1)) : j_r - INDEX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      period_r <= '0;
      xc_r     <= '0;
      yc_r     <= '0;
      drop_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      xc_r    <= xc_nxt;
      yc_r    <= yc_nxt;
      drop_r  <= drop_nxt;
      if (cfg_we) period_r <= cfg_wdata;
    end
  end

  // Loop registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    imax_r    <= imax_nxt;
    ycrun_r   <= ycrun_nxt;
    droprun_r <= droprun_nxt;
    k_r       <= k_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
  end

endmodule

// File: sv/cc_datapath.sv
// cc_datapath: sample memories, multiplier, accumulator and output register
// of the circular convolution block. Three stages, frozen on output stall.
// Depends on cc_pkg.
module cc_datapath import cc_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output stat_t                         stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [INDEX_W-1:0]            out_index,
  output logic signed [VALUE_W-1:0]     out_value,
  output logic                          out_last,
  output logic                          out_dropped
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PW = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] x_mem [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] y_mem [MAX_LEN];

  logic                          run;
  logic                          s1_valid_r, s2_valid_r;
  tag_t                          s1_tag_r, s2_tag_r;
  logic signed [SAMPLE_BITS-1:0] x_rd_r, y_rd_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [VALUE_W-1:0]     acc_r, acc_nxt, term;
  logic                          out_valid_r;
  logic [INDEX_W-1:0]            out_index_r;
  logic signed [VALUE_W-1:0]     out_value_r;
  logic                          out_last_r, out_dropped_r;

  // Whole pipeline holds while a result waits
  assign run       = !out_valid_r || out_ready;
  assign stat.run  = run;
  assign stat.busy = s1_valid_r || s2_valid_r;

  // Sample stores: load writes, registered reads for compute
  always_ff @(posedge clk) begin
    if (cmd.wr_x) x_mem[cmd.wa[AW-1:0]] <= sample;
    if (cmd.wr_y) y_mem[cmd.wa[AW-1:0]] <= sample;
    if (run && cmd.valid) begin
      x_rd_r <= x_mem[cmd.xa[AW-1:0]];
      y_rd_r <= y_mem[cmd.ya[AW-1:0]];
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (run) begin
      s1_valid_r  <= cmd.valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && s2_tag_r.fin;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (run) begin
      s1_tag_r <= cmd.tag;
      s2_tag_r <= s1_tag_r;
      prod_r   <= x_rd_r * y_rd_r;
    end
  end

  // Accumulate; sum wraps to the output width
  assign term    = s2_tag_r.use_term ? VALUE_W'(prod_r) : '0;
  assign acc_nxt = s2_tag_r.first ? term : acc_r + term;

  always_ff @(posedge clk) begin
    if (run && s2_valid_r) begin
      acc_r <= acc_nxt;
      if (s2_tag_r.fin) begin
        out_index_r   <= s2_tag_r.k;
        out_value_r   <= acc_nxt;
        out_last_r    <= s2_tag_r.last;
        out_dropped_r <= s2_tag_r.dropped;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_index   = out_index_r;
  assign out_value   = out_value_r;
  assign out_last    = out_last_r;
  assign out_dropped = out_dropped_r;

endmodule

// File: sv/circular_convolution.sv
// circular_convolution: top level; loads two sample vectors and emits their
// circular convolution over a configured period.
// Depends on cc_pkg, cc_ctrl and cc_datapath.
//
//  channel  | direction | tdata                          | tuser        | tlast
//  ---------+-----------+--------------------------------+--------------+-----------
//  in_      | slave     | sample                         | mode         | -
//  out_     | master    | out_index [5:0], out_value     | dropped      | last
//           |           | [43:6], zero above             |              |
//  cfg_     | write     | period_len in cfg_wdata        | -            | -
//
// A load transaction leaves in_tready high. A compute transaction issues
// n * max(1, min(n, x_count)) product terms via the single multiplier, one per cycle
// unless the output stalls; in_tready returns once read and multiply stages drain.
// Synchronous active-low reset clears counts, drop flag, period and valids.
// An output stall freezes the whole term pipeline until the result is taken.
module circular_convolution import cc_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,   // sample
  input  logic [MODE_W-1:0]                      in_tuser,   // mode
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [OUT_TDATA_W-1:0]                 out_tdata,  // out_index, out_value
  output logic                                   out_tuser,  // dropped
  output logic                                   out_tlast,
  input  logic                                   cfg_we,
  input  logic [PERIOD_W-1:0]                    cfg_wdata   // period_len
);

  cmd_t                      cmd;
  stat_t                     stat;
  logic [INDEX_W-1:0]        out_index;
  logic signed [VALUE_W-1:0] out_value;

  cc_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd)
  );

  cc_datapath #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sample      (in_tdata[SAMPLE_BITS-1:0]),
    .stat        (stat),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_index   (out_index),
    .out_value   (out_value),
    .out_last    (out_tlast),
    .out_dropped (out_tuser)
  );

  // Pack result fields, lowest first
  assign out_tdata = {{(OUT_TDATA_W - VALUE_W - INDEX_W){1'b0}}, out_value, out_index};

endmodule

// File: sv/cc_checker.sv
// cc_checker: port-level checks for circular_convolution, bound to the top.
// Depends on cc_pkg and circular_convolution.
module cc_checker import cc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [MODE_W-1:0]      in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Reset leaves the input side ready
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("in_tready low after reset");

  // A non-compute transaction leaves the input ready in the next cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != MODE_COMPUTE |=> in_tready)
    else $error("load transaction held the input");

  // Input only closes after a compute transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tuser == MODE_COMPUTE))
    else $error("input closed without a compute transaction");

  // Index 63 only exists as the final result of a full period
  a_top_index_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[INDEX_W-1:0] == {INDEX_W{1'b1}} |-> out_tlast)
    else $error("highest index not marked last");

endmodule

bind circular_convolution cc_checker u_cc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/tb_circular_convolution.sv
// tb_circular_convolution: self-checking testbench for the circular convolution block.
// Predicts every result in SystemVerilog, drives random bursts and stalls on both streams.
// Depends on cc_pkg and circular_convolution.
module tb_circular_convolution import cc_pkg::*;;

  localparam int MAX_LEN        = DEF_MAX_LEN;
  localparam int IN_TDATA_W     = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;     // block drains its pipeline after its last term
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int STALL_LIMIT    = 20000; // cycles without any transaction
  localparam int RANDOM_ITEMS   = 360;
  localparam int RANDOM_PHASES  = 8;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // One expected output transaction
  typedef struct {
    logic [INDEX_W-1:0]        pos;
    logic signed [VALUE_W-1:0] sum;
    logic                      last;
    logic                      dropped;
  } conv_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;     // sample
  logic [MODE_W-1:0]      in_tuser   = '0;     // mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;           // out_index [5:0], out_value [43:6]
  logic                   out_tuser;           // dropped
  logic                   out_tlast;           // last
  logic                   cfg_we     = 1'b0;
  logic [PERIOD_W-1:0]    cfg_wdata  = '0;     // period_len

  // Predictor state
  logic signed [IN_TDATA_W-1:0] x_vals [MAX_LEN];
  logic signed [IN_TDATA_W-1:0] y_vals [MAX_LEN];
  int   x_len        = 0;
  int   y_len        = 0;
  logic drop_pending = 1'b0;
  int   period_reg   = 0;
  conv_result_t conv_sums_due [$];

  // Run bookkeeping
  int   mismatches  = 0;
  int   n_loads     = 0;
  int   n_computes  = 0;
  int   n_ignored   = 0;
  int   n_drop_runs = 0;
  int   n_results   = 0;
  int   n_cfg       = 0;
  int   burst_left  = 0;
  int   quiet_cycles = 0;
  logic hold_req    = 1'b0;

  always #5 clk = ~clk;

  circular_convolution #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(DEF_SAMPLE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Update the vectors for one accepted transaction and queue the sums it produces
  function automatic void convolve_step(input logic [MODE_W-1:0] mode,
                                        input logic [IN_TDATA_W-1:0] smp);
    int n;
    int k;
    int i;
    int j;
    longint acc;
    conv_result_t r;
    case (mode)
      MODE_LOAD_X: begin
        n_loads++;
        if (x_len < MAX_LEN) begin
          x_vals[x_len] = smp;
          x_len++;
        end else begin
          drop_pending = 1'b1;
        end
      end
      MODE_LOAD_Y: begin
        n_loads++;
        if (y_len < MAX_LEN) begin
          y_vals[y_len] = smp;
          y_len++;
        end else begin
          drop_pending = 1'b1;
        end
      end
      MODE_COMPUTE: begin
        n_computes++;
        n = period_reg;
        if (n == 0 && x_len != 0 && y_len != 0) n = x_len + y_len - 1;
        if (n > int'(MAX_PERIOD)) n = int'(MAX_PERIOD);
        if (drop_pending && n != 0) n_drop_runs++;
        for (k = 0; k < n; k++) begin
          acc = 0;
          for (i = 0; i < n && i < x_len; i++) begin
            j = (k + n - i) % n;
            if (j < y_len) acc += longint'(x_vals[i]) * longint'(y_vals[j]);
          end
          r.pos     = INDEX_W'(k);
          r.sum     = acc[VALUE_W-1:0];
          r.last    = (k + 1 == n);
          r.dropped = drop_pending;
          conv_sums_due.push_back(r);
        end
        // compute always empties both vectors
        x_len        = 0;
        y_len        = 0;
        drop_pending = 1'b0;
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic logic [IN_TDATA_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      default: return IN_TDATA_W'($urandom);
    endcase
  endfunction

  // Offer one transaction, in bursts separated by random gaps
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IN_TDATA_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    convolve_step(mode, smp);
  endtask

  // Loads into x and y in random order, with occasional unused-mode noise
  task automatic load_mixed(input int nx, input int ny);
    while (nx > 0 || ny > 0) begin
      if ($urandom_range(0, 19) == 0) send_item(MODE_UNUSED, rand_sample());
      if (ny == 0 || (nx > 0 && $urandom_range(0, 1) == 1)) begin
        send_item(MODE_LOAD_X, rand_sample());
        nx--;
      end else begin
        send_item(MODE_LOAD_Y, rand_sample());
        ny--;
      end
    end
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic wait_idle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (conv_sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    period_reg = v;
    n_cfg++;
  endtask

  // Default period: linear length, empty-vector cases, extremes, unused mode
  task automatic test_default_period();
    write_period(7'd0);
    send_item(MODE_COMPUTE, 16'h0000);      // both empty: no output
    send_item(MODE_LOAD_X, 16'h0009);
    send_item(MODE_COMPUTE, 16'hFFFF);      // y empty: no output, x cleared
    send_item(MODE_LOAD_X, 16'd1);
    send_item(MODE_LOAD_X, 16'd2);
    send_item(MODE_LOAD_X, 16'd3);
    send_item(MODE_LOAD_Y, 16'd4);
    send_item(MODE_LOAD_Y, -16'sd5);
    send_item(MODE_UNUSED, 16'hFFFF);       // ignored
    send_item(MODE_COMPUTE, 16'h0000);
    send_item(MODE_LOAD_X, 16'h8000);
    send_item(MODE_LOAD_X, 16'h7FFF);
    send_item(MODE_LOAD_Y, 16'h8000);
    send_item(MODE_LOAD_Y, 16'h8000);
    send_item(MODE_LOAD_Y, 16'h7FFF);
    send_item(MODE_COMPUTE, 16'h5555);
  endtask

  // Explicit periods: saturation, empty x, truncation of x and wraparound
  task automatic test_explicit_period();
    write_period(7'd127);                   // saturates to 64
    send_item(MODE_LOAD_Y, 16'd7);
    send_item(MODE_COMPUTE, 16'h0000);      // x empty: 64 zero sums
    write_period(7'd1);
    send_item(MODE_LOAD_X, 16'h7FFF);
    send_item(MODE_LOAD_X, 16'd5);
    send_item(MODE_LOAD_Y, 16'hFFFF);
    send_item(MODE_LOAD_Y, 16'd3);
    send_item(MODE_COMPUTE, 16'h0000);
    write_period(7'd3);
    load_mixed(5, 2);
    send_item(MODE_COMPUTE, 16'h0000);
  endtask

  // Overfill both vectors with the most negative sample, then check the flag clears
  task automatic test_vector_full();
    int i;
    write_period(7'd64);
    for (i = 0; i < MAX_LEN + 2; i++) send_item(MODE_LOAD_X, 16'h8000);
    for (i = 0; i < MAX_LEN + 1; i++) send_item(MODE_LOAD_Y, 16'h8000);
    send_item(MODE_COMPUTE, 16'h0000);
    send_item(MODE_LOAD_X, 16'd2);
    send_item(MODE_LOAD_Y, 16'd3);
    send_item(MODE_COMPUTE, 16'h0000);
  endtask

  // Receiver holds off for a long stretch while loads and computes keep coming
  task automatic test_backpressure();
    write_period(7'd0);
    hold_req = 1'b1;
    load_mixed(5, 5);
    send_item(MODE_COMPUTE, rand_sample());
    load_mixed(3, 2);
    send_item(MODE_COMPUTE, rand_sample());
    load_mixed(4, 4);
    send_item(MODE_COMPUTE, rand_sample());
  endtask

  // One random run: mostly well-formed, some overfilled, empty or broken
  task automatic random_run();
    int kind;
    int nx;
    int ny;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      nx = $urandom_range(1, 8);
      ny = $urandom_range(1, 8);
    end else if (kind < 75) begin
      nx = $urandom_range(1, MAX_LEN);
      ny = $urandom_range(1, MAX_LEN);
    end else if (kind < 82) begin
      nx = $urandom_range(MAX_LEN - 2, MAX_LEN + 4);
      ny = $urandom_range(MAX_LEN - 4, MAX_LEN + 3);
    end else if (kind < 92) begin
      nx = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      ny = (nx == 0) ? $urandom_range(0, 6) : 0;
    end else begin
      nx = $urandom_range(0, 3);
      ny = $urandom_range(0, 3);
    end
    load_mixed(nx, ny);
    // broken runs leave their samples for the next one
    if (kind < 96) send_item(MODE_COMPUTE, rand_sample());
  endtask

  task automatic test_random_runs();
    int p;
    int start;
    logic [PERIOD_W-1:0] setting;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0:       setting = 7'd0;
        1:       setting = PERIOD_W'($urandom_range(1, 8));
        2:       setting = PERIOD_W'($urandom_range(9, 64));
        default: setting = PERIOD_W'($urandom_range(65, 127));
      endcase
      write_period(setting);
      start = n_loads + n_computes;
      while (n_loads + n_computes - start < RANDOM_ITEMS / RANDOM_PHASES) random_run();
    end
  endtask

  // Receiver stall pattern: stretches of varying readiness, plus the long hold
  initial begin : rx_pattern
    int stretch_left;
    int ready_pct;
    stretch_left = 0;
    ready_pct    = 100;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(4, 60);
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 80;
            2:       ready_pct = 50;
            default: ready_pct = 20;
          endcase
        end
        stretch_left--;
        out_tready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // Compare each output transaction with the oldest expected sum
  always @(posedge clk) begin : result_check
    conv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (conv_sums_due.size() == 0) begin
        $error("unexpected result: out_index %0d out_value %0d",
               out_tdata[INDEX_W-1:0], $signed(out_tdata[INDEX_W +: VALUE_W]));
        mismatches++;
      end else begin
        want = conv_sums_due.pop_front();
        n_results++;
        if (out_tdata[INDEX_W-1:0] !== want.pos) begin
          $error("out_index: expected %0d, got %0d", want.pos, out_tdata[INDEX_W-1:0]);
          mismatches++;
        end
        if (out_tdata[INDEX_W +: VALUE_W] !== want.sum) begin
          $error("out_value: expected %0d, got %0d", want.sum,
                 $signed(out_tdata[INDEX_W +: VALUE_W]));
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          mismatches++;
        end
        if (out_tuser !== want.dropped) begin
          $error("dropped: expected %0b, got %0b", want.dropped, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction happens for too long
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_period();
    test_explicit_period();
    test_vector_full();
    test_backpressure();
    test_random_runs();
    wait_idle();
    $display("Covered %0d loads, %0d computes, %0d ignored items, %0d period writes.",
             n_loads, n_computes, n_ignored, n_cfg);
    $display("Checked %0d results, %0d runs with overflowed vectors, %0d mismatches.",
             n_results, n_drop_runs, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
